[hw/rtl/hss_pkg.sv]
// Package with shared types and constants of the Heun sampler step block.
package hss_pkg;
  localparam int unsigned MaxElements = 16384;
  localparam int unsigned PosW = 14;
  localparam int unsigned DataW = 32;
  localparam int unsigned SigW = 31;
  localparam int unsigned StepW = 12;
  localparam int unsigned AddrW = 5;

  localparam logic [AddrW-1:0] RegSigPrev = 5'd0;
  localparam logic [AddrW-1:0] RegSigCur = 5'd4;
  localparam logic [AddrW-1:0] RegSigNext = 5'd8;
  localparam logic [AddrW-1:0] RegRecip = 5'd12;
  localparam logic [AddrW-1:0] RegStep = 5'd16;

  typedef enum logic [1:0] {
    MODE_FINAL = 2'd0,
    MODE_PRED  = 2'd1,
    MODE_CORR  = 2'd2
  } mode_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic [PosW-1:0]         pos;
    mode_t                   mode;
    logic signed [DataW-1:0] samp;
    logic signed [DataW-1:0] deriv;
  } work_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction
endpackage

[hw/rtl/hss_if.sv]
// Valid/ready channel interfaces for requests and results.
interface hss_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] element_index;
  logic signed [31:0] predicted_value;
  logic signed [31:0] sample_value;
  modport source (output valid, element_index, predicted_value, sample_value, input ready);
  modport sink (input valid, element_index, predicted_value, sample_value, output ready);
endinterface

interface hss_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] element_position;
  logic signed [31:0] next_sample;
  modport source (output valid, element_position, next_sample, input ready);
  modport sink (input valid, element_position, next_sample, output ready);
endinterface

[hw/rtl/hss_front.sv]
// Front part: derivative computation and step classification, two stages.
module hss_front (
  input  logic                 clk,
  input  logic                 rst,
  hss_in_if.sink               in_ch,
  input  logic [30:0]          recip,
  input  logic [30:0]          sig_next,
  input  logic                 odd_step,
  output logic                 wvalid,
  output hss_pkg::work_t       wdata,
  input  logic                 wready
);
  import hss_pkg::*;

  logic                 s1_valid;
  logic [PosW-1:0]      s1_pos;
  mode_t                s1_mode;
  logic signed [31:0]   s1_samp;
  logic signed [63:0]   s1_prod;
  logic                 adv;
  logic signed [32:0]   diff;
  logic signed [65:0]   rnd;

  assign adv = !wvalid || wready;
  assign in_ch.ready = adv;
  assign diff = 33'(in_ch.sample_value) - 33'(in_ch.predicted_value);
  assign rnd = 66'(s1_prod) + 66'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_ch.valid;
      wvalid <= s1_valid;
    end
    if (adv) begin
      s1_pos <= in_ch.element_index;
      s1_samp <= in_ch.sample_value;
      s1_prod <= 64'(diff) * 64'($signed({1'b0, recip}));
      if (sig_next == '0) s1_mode <= MODE_FINAL;
      else if (odd_step) s1_mode <= MODE_CORR;
      else s1_mode <= MODE_PRED;
      wdata.pos <= s1_pos;
      wdata.mode <= s1_mode;
      wdata.samp <= s1_samp;
      wdata.deriv <= sat32(rnd >>> 16);
    end
  end
endmodule

[hw/rtl/hss_queue.sv]
// Two-entry queue between the front and back parts.
module hss_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           ivalid,
  input  hss_pkg::work_t idata,
  output logic           iready,
  output logic           ovalid,
  output hss_pkg::work_t odata,
  input  logic           oready
);
  import hss_pkg::*;

  work_t       mem [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic        push, pop;

  assign iready = cnt != 2'd2;
  assign ovalid = cnt != 2'd0;
  assign odata = mem[rp];
  assign push = ivalid && iready;
  assign pop = ovalid && oready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= idata;
  end
endmodule

[hw/rtl/hss_back.sv]
// Back part: store access, corrector average, dt product and saturating update.
module hss_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           ivalid,
  input  hss_pkg::work_t idata,
  output logic           iready,
  input  logic [30:0]    sig_prev,
  input  logic [30:0]    sig_cur,
  input  logic [30:0]    sig_next,
  input  logic           odd_step,
  hss_out_if.source      out_ch
);
  import hss_pkg::*;

  localparam int unsigned SlotW = (MaxElements > 1) ? $clog2(MaxElements) : 1;

  logic signed [31:0] dmem [MaxElements];
  logic signed [31:0] smem [MaxElements];

  logic               adv;
  logic [SlotW-1:0]   slot;
  logic               a_valid, b_valid, c_valid;
  work_t              a_w;
  logic signed [31:0] a_rd, a_rs;
  logic [PosW-1:0]    b_pos, c_pos;
  logic signed [31:0] b_base, c_base;
  logic signed [31:0] b_factor;
  logic signed [32:0] avg_sum;
  logic signed [31:0] dt;
  logic signed [63:0] c_prod;
  logic signed [65:0] sum;

  assign adv = !out_ch.valid || out_ch.ready;
  assign iready = adv;
  assign slot = SlotW'(idata.pos % MaxElements);
  assign avg_sum = 33'(a_rd) + 33'(a_w.deriv) + 33'sd1;
  assign dt = odd_step ? 32'($signed({1'b0, sig_cur}) - $signed({1'b0, sig_prev}))
                       : 32'($signed({1'b0, sig_next}) - $signed({1'b0, sig_cur}));
  assign sum = 66'(c_base) + ((66'(c_prod) + 66'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      a_valid <= ivalid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      out_ch.valid <= c_valid;
    end
    if (adv) begin
      // Store read and write share one stage so a later read sees the latest write.
      a_rd <= dmem[slot];
      a_rs <= smem[slot];
      a_w <= idata;
      if (ivalid && idata.mode == MODE_PRED) begin
        dmem[slot] <= idata.deriv;
        smem[slot] <= idata.samp;
      end
      b_pos <= a_w.pos;
      if (a_w.mode == MODE_CORR) begin
        b_base <= a_rs;
        b_factor <= avg_sum[32:1];
      end else begin
        b_base <= a_w.samp;
        b_factor <= a_w.deriv;
      end
      c_pos <= b_pos;
      c_base <= b_base;
      c_prod <= 64'(b_factor) * 64'(dt);
      out_ch.element_position <= c_pos;
      out_ch.next_sample <= sat32(sum);
    end
  end
endmodule

[hw/rtl/heun_sampler_step_top.sv]
// Request path: the front stages, the queue, then back stages a, b, c and the output register.
// Throughput: one request per cycle while results are taken; the two multipliers are pipelined stages.
// The saved derivative and sample stores are single memories, read and written in one stage.
// Reset clears control state and loads register defaults; stores are not cleared.
// Results stall the back pipeline; the queue lets the front keep accepting briefly.
module heun_sampler_step_top (
  input  logic        clk,
  input  logic        rst,
  hss_in_if.sink      in_ch,
  hss_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hss_pkg::*;

  logic [30:0] sig_prev, sig_cur, sig_next, recip;
  logic [11:0] step_num;
  logic        fvalid, fready, qvalid, qready;
  work_t       fdata, qdata;

  assign pready = 1'b1;

  // Configuration registers, written in the access phase of a request.
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_prev <= '0;
      sig_cur <= 31'd65536;
      sig_next <= '0;
      recip <= 31'd65536;
      step_num <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegSigPrev: sig_prev <= pwdata[30:0];
        RegSigCur:  sig_cur <= pwdata[30:0];
        RegSigNext: sig_next <= pwdata[30:0];
        RegRecip:   recip <= pwdata[30:0];
        RegStep:    step_num <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      RegSigPrev: prdata = {1'b0, sig_prev};
      RegSigCur:  prdata = {1'b0, sig_cur};
      RegSigNext: prdata = {1'b0, sig_next};
      RegRecip:   prdata = {1'b0, recip};
      RegStep:    prdata = {20'd0, step_num};
      default:    prdata = '0;
    endcase
  end

  hss_front u_front (
    .clk, .rst, .in_ch, .recip, .sig_next, .odd_step(step_num[0]),
    .wvalid(fvalid), .wdata(fdata), .wready(fready)
  );

  hss_queue u_queue (
    .clk, .rst, .ivalid(fvalid), .idata(fdata), .iready(fready),
    .ovalid(qvalid), .odata(qdata), .oready(qready)
  );

  hss_back u_back (
    .clk, .rst, .ivalid(qvalid), .idata(qdata), .iready(qready),
    .sig_prev, .sig_cur, .sig_next, .odd_step(step_num[0]), .out_ch
  );
endmodule
